// ===== hw/rtl/tsl_pkg.sv =====
// ----------------------------------------------------------------------------
// tsl_pkg
// Shared widths, fixed-point format and codes for the trailing stop-loss check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsl_pkg;

	// field widths
	localparam int SYM_W      = 6;
	localparam int PRICE_W    = 32;
	localparam int QTY_W      = 32;
	localparam int SELL_QTY_W = 31;
	localparam int REASON_W   = 2;

	// unsigned fractions, 1.0 = 1 << FRACTION_BITS
	localparam int FRACTION_BITS = 16;
	localparam int FRAC_W        = FRACTION_BITS + 1;
	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRACTION_BITS;

	// wide enough for both sides of the cross-multiplied compare
	localparam int CMP_W = PRICE_W + FRAC_W;

	// trigger reasons
	localparam logic [REASON_W-1:0] REASON_NONE  = 2'd0;
	localparam logic [REASON_W-1:0] REASON_FIXED = 2'd1;
	localparam logic [REASON_W-1:0] REASON_TRAIL = 2'd2;

	// input actions
	localparam logic ACTION_CHECK = 1'b0;
	localparam logic ACTION_CLEAR = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECKS_EN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_FRAC  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_EN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_FRAC = 2'd3;

endpackage

// ===== hw/rtl/tsl_drop_cmp.sv =====
// ----------------------------------------------------------------------------
// tsl_drop_cmp
// Exact test of (top - price) / top >= frac by cross-multiplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsl_drop_cmp (
	input  logic [tsl_pkg::PRICE_W-1:0] top,
	input  logic [tsl_pkg::PRICE_W-1:0] price,
	input  logic [tsl_pkg::FRAC_W-1:0]  frac,
	output logic                        hit
);
	import tsl_pkg::*;

	logic [PRICE_W-1:0] diff;
	logic [CMP_W-1:0]   lhs;
	logic [CMP_W-1:0]   rhs;

	// scaled drop against threshold times reference
	assign diff = top - price;
	assign lhs  = CMP_W'(diff) << FRACTION_BITS;
	assign rhs  = CMP_W'(frac) * CMP_W'(top);

	// a price above the reference never counts as a drop
	assign hit = (price <= top) && (lhs >= rhs);

endmodule

// ===== hw/rtl/trailing_stop_loss_check.sv =====
// ----------------------------------------------------------------------------
// trailing_stop_loss_check
// Per-symbol fixed and trailing stop-loss check with a peak price table.
// Pipeline: the input transfer loads stage 1 and the peak table read; the
//   result register loads from stage 1 as the output advances.
// Throughput: one item per cycle unless the output stalls; the peak table read
//   is registered at input transfer and the previous item's write is forwarded.
// Reset: config registers return to defaults and all peak entries read as
//   zero at once through per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trailing_stop_loss_check #(
	parameter int SYMBOLS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [tsl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tsl_pkg::FRAC_W-1:0]          cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic [tsl_pkg::SYM_W-1:0]           symbol_index,
	input  logic [tsl_pkg::PRICE_W-1:0]         tick_price,
	input  logic signed [tsl_pkg::QTY_W-1:0]    held_qty,
	input  logic [tsl_pkg::PRICE_W-1:0]         average_cost,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                sell_trigger,
	output logic [tsl_pkg::REASON_W-1:0]        trigger_reason,
	output logic [tsl_pkg::SYM_W-1:0]           sell_symbol,
	output logic [tsl_pkg::SELL_QTY_W-1:0]      sell_qty
);
	import tsl_pkg::*;

	// only indexes reachable by the symbol field get storage
	localparam int DEPTH = (SYMBOLS < (2 ** SYM_W)) ? SYMBOLS : (2 ** SYM_W);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [SYM_W:0] DEPTH_L = (SYM_W + 1)'(DEPTH);

	// configuration registers
	logic                checks_en_q;
	logic [FRAC_W-1:0]   stop_frac_q;
	logic                trail_en_q;
	logic [FRAC_W-1:0]   trail_frac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checks_en_q  <= 1'b0;
			stop_frac_q  <= FRAC_ONE;
			trail_en_q   <= 1'b0;
			trail_frac_q <= FRAC_ONE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHECKS_EN:  checks_en_q  <= cfg_data[0];
				CFG_STOP_FRAC:  stop_frac_q  <= cfg_data;
				CFG_TRAIL_EN:   trail_en_q   <= cfg_data[0];
				CFG_TRAIL_FRAC: trail_frac_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	logic vld_s1;
	logic adv;
	logic in_xfer;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = vld_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;

	// stage 1 payload
	logic                      action_s1;
	logic [SYM_W-1:0]          sym_s1;
	logic [PRICE_W-1:0]        price_s1;
	logic signed [QTY_W-1:0]   qty_s1;
	logic [PRICE_W-1:0]        cost_s1;
	logic [PRICE_W-1:0]        rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_xfer) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			action_s1 <= action;
			sym_s1    <= symbol_index;
			price_s1  <= tick_price;
			qty_s1    <= held_qty;
			cost_s1   <= average_cost;
		end
	end

	// peak table storage, registered read at the input transfer
	logic [PRICE_W-1:0] peak_mem [DEPTH];
	logic [DEPTH-1:0]   peak_vld_q;
	logic               wr_en;
	logic [IDX_W-1:0]   idx_s1;
	logic [PRICE_W-1:0] new_peak;

	assign idx_s1 = sym_s1[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rd_s1 <= peak_mem[symbol_index[IDX_W-1:0]];
		end
		if (wr_en) begin
			peak_mem[idx_s1] <= new_peak;
		end
	end

	// last write, forwarded over the stale registered read
	logic               wr_vld_q;
	logic [IDX_W-1:0]   wr_idx_q;
	logic [PRICE_W-1:0] wr_data_q;

	logic in_range;
	logic clr_en;
	logic do_check;

	assign in_range = {1'b0, sym_s1} < DEPTH_L;
	assign do_check = (action_s1 == ACTION_CHECK) && checks_en_q
		&& (qty_s1 > 0) && (cost_s1 != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_vld_q <= '0;
			wr_vld_q   <= 1'b0;
		end else begin
			if (clr_en) begin
				peak_vld_q[idx_s1] <= 1'b0;
			end else if (wr_en) begin
				peak_vld_q[idx_s1] <= 1'b1;
				wr_vld_q           <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wr_idx_q  <= idx_s1;
			wr_data_q <= new_peak;
		end
	end

	// peak update
	logic [PRICE_W-1:0] peak_raw;
	logic [PRICE_W-1:0] peak_old;
	logic [PRICE_W-1:0] peak_base;

	assign peak_raw  = (wr_vld_q && (wr_idx_q == idx_s1)) ? wr_data_q : rd_s1;
	assign peak_old  = peak_vld_q[idx_s1] ? peak_raw : '0;
	assign peak_base = (peak_old == '0) ? cost_s1 : peak_old;
	assign new_peak  = (price_s1 > peak_base) ? price_s1 : peak_base;

	// threshold tests
	logic fixed_hit;
	logic trail_hit;

	tsl_drop_cmp u_fixed_cmp (
		.top   (cost_s1),
		.price (price_s1),
		.frac  (stop_frac_q),
		.hit   (fixed_hit)
	);

	tsl_drop_cmp u_trail_cmp (
		.top   (new_peak),
		.price (price_s1),
		.frac  (trail_frac_q),
		.hit   (trail_hit)
	);

	// table writes happen as the item leaves stage 1
	assign clr_en = vld_s1 && adv && in_range && (action_s1 == ACTION_CLEAR);
	assign wr_en  = vld_s1 && adv && in_range && do_check && !fixed_hit && trail_en_q;

	logic [REASON_W-1:0] reason;

	always_comb begin
		reason = REASON_NONE;
		if (in_range && do_check) begin
			if (fixed_hit) begin
				reason = REASON_FIXED;
			end else if (trail_en_q && trail_hit) begin
				reason = REASON_TRAIL;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			sell_trigger   <= (reason != REASON_NONE);
			trigger_reason <= reason;
			sell_symbol    <= sym_s1;
			sell_qty       <= (reason != REASON_NONE) ? qty_s1[SELL_QTY_W-1:0] : '0;
		end
	end

endmodule

// ===== hw/rtl/tsl_check.sv =====
// ----------------------------------------------------------------------------
// tsl_check
// Port-level checks on the result channel of the stop-loss block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsl_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           sell_trigger,
	input  logic [tsl_pkg::REASON_W-1:0]   trigger_reason,
	input  logic [tsl_pkg::SYM_W-1:0]      sell_symbol,
	input  logic [tsl_pkg::SELL_QTY_W-1:0] sell_qty
);
	import tsl_pkg::*;

	// a stalled result stays put until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(trigger_reason)
		&& $stable(sell_symbol) && $stable(sell_qty))
		else $error("stalled result changed");

	// trigger flag agrees with the reason code
	a_trig_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sell_trigger == (trigger_reason != REASON_NONE)))
		else $error("trigger flag and reason disagree");

	// only the defined reason codes appear
	a_reason_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (trigger_reason == REASON_NONE) || (trigger_reason == REASON_FIXED)
		|| (trigger_reason == REASON_TRAIL))
		else $error("undefined trigger reason");

	// no quantity without a sell order
	a_qty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sell_trigger |-> (sell_qty == '0))
		else $error("sell quantity without trigger");

endmodule

bind trailing_stop_loss_check tsl_check u_tsl_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.sell_trigger   (sell_trigger),
	.trigger_reason (trigger_reason),
	.sell_symbol    (sell_symbol),
	.sell_qty       (sell_qty)
);

// ===== tb/tb_trailing_stop_loss_check.sv =====
// ----------------------------------------------------------------------------
// tb_trailing_stop_loss_check
// Self-checking bench for the per-symbol fixed and trailing stop-loss check.
// A clocked driver feeds price ticks from a queue and idles at random. A
// clocked monitor stalls at random, holds off once for a long stretch, and
// checks every sell decision against a local model of the peak table and
// the cross-multiplied threshold compares. Settings change between phases
// only once the block has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_trailing_stop_loss_check;

	import tsl_pkg::*;

	localparam int NUM_SYMBOLS   = 64;
	localparam int RESET_CYCLES  = 11;
	localparam int DRAIN_CYCLES  = 4;
	localparam int IDLE_PCT      = 27;
	localparam int HOLD_AT       = 600;
	localparam int HOLD_CYCLES   = 80;
	localparam int STUCK_LIMIT   = 4000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_TICKS   = 225;

	typedef struct {
		logic                    action;
		logic [SYM_W-1:0]        symbol;
		logic [PRICE_W-1:0]      price;
		logic signed [QTY_W-1:0] qty;
		logic [PRICE_W-1:0]      cost;
	} tick_t;

	typedef struct {
		logic                  trig;
		logic [REASON_W-1:0]   reason;
		logic [SYM_W-1:0]      symbol;
		logic [SELL_QTY_W-1:0] qty;
	} sell_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = CFG_CHECKS_EN;
	logic [FRAC_W-1:0]       cfg_data = '0;

	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    action = ACTION_CHECK;
	logic [SYM_W-1:0]        symbol_index = '0;
	logic [PRICE_W-1:0]      tick_price = '0;
	logic signed [QTY_W-1:0] held_qty = '0;
	logic [PRICE_W-1:0]      average_cost = '0;

	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    sell_trigger;
	logic [REASON_W-1:0]     trigger_reason;
	logic [SYM_W-1:0]        sell_symbol;
	logic [SELL_QTY_W-1:0]   sell_qty;

	// model copy of the peak table and settings
	logic [PRICE_W-1:0] peak_tab [NUM_SYMBOLS];
	logic               chk_en = 1'b0;
	logic [FRAC_W-1:0]  stop_frac = FRAC_ONE;
	logic               trail_en = 1'b0;
	logic [FRAC_W-1:0]  trail_frac = FRAC_ONE;

	tick_t       pending_ticks [$];
	sell_t       expected_sells [$];
	tick_t       drv_tick;
	logic        steady = 1'b0;
	int unsigned errors = 0;
	int unsigned sells_seen = 0;
	int unsigned hold_left = 0;
	int unsigned stuck_cycles = 0;

	trailing_stop_loss_check #(
		.SYMBOLS(NUM_SYMBOLS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.symbol_index(symbol_index),
		.tick_price(tick_price),
		.held_qty(held_qty),
		.average_cost(average_cost),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sell_trigger(sell_trigger),
		.trigger_reason(trigger_reason),
		.sell_symbol(sell_symbol),
		.sell_qty(sell_qty)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// exact (top - price) / top >= frac compare by cross-multiplication
	function automatic logic drop_hits(logic [PRICE_W-1:0] top, logic [PRICE_W-1:0] price,
			logic [FRAC_W-1:0] frac);
		logic [63:0] lhs;
		logic [63:0] rhs;
		rhs = 64'(frac) * 64'(top);
		lhs = 64'(top - price) << FRACTION_BITS;
		return (price <= top) && (lhs >= rhs);
	endfunction

	// sell decision for one tick, updating the model peak table
	function automatic sell_t judge_tick(tick_t t);
		sell_t s;
		logic [PRICE_W-1:0] peak;
		s.reason = REASON_NONE;
		if (t.action == ACTION_CLEAR) begin
			peak_tab[t.symbol] = '0;
		end else if (chk_en && t.qty > 0 && t.cost != '0) begin
			if (drop_hits(t.cost, t.price, stop_frac)) begin
				s.reason = REASON_FIXED;
			end else if (trail_en) begin
				peak = peak_tab[t.symbol];
				// untracked symbol starts from its entry cost
				if (peak == '0)
					peak = t.cost;
				if (t.price > peak)
					peak = t.price;
				peak_tab[t.symbol] = peak;
				if (drop_hits(peak, t.price, trail_frac))
					s.reason = REASON_TRAIL;
			end
		end
		s.trig = (s.reason != REASON_NONE);
		s.symbol = t.symbol;
		s.qty = s.trig ? t.qty[SELL_QTY_W-1:0] : '0;
		return s;
	endfunction

	function automatic tick_t mk_tick(logic act, logic [SYM_W-1:0] sym, logic [PRICE_W-1:0] price,
			logic [QTY_W-1:0] qty, logic [PRICE_W-1:0] cost);
		tick_t t;
		t.action = act;
		t.symbol = sym;
		t.price = price;
		t.qty = qty;
		t.cost = cost;
		return t;
	endfunction

	// append one tick to the driver queue
	function automatic void add_tick(tick_t t);
		pending_ticks.insert(pending_ticks.size(), t);
	endfunction

	// mostly prices near the entry cost on a few symbols, some raw noise
	function automatic tick_t rand_tick();
		tick_t t;
		logic [PRICE_W-1:0] base;
		logic [PRICE_W-1:0] delta;
		int unsigned r;
		r = $urandom_range(99);
		t.action = ($urandom_range(99) < 6) ? ACTION_CLEAR : ACTION_CHECK;
		t.symbol = ($urandom_range(3) == 0) ? SYM_W'($urandom) : SYM_W'($urandom_range(7));
		if (r < 10) begin
			t.price = $urandom;
			t.qty = $urandom;
			t.cost = $urandom;
		end else begin
			base = (r < 20) ? $urandom : $urandom_range(200000, 1000);
			delta = $urandom_range(base >> 2, 0);
			t.cost = (r < 23) ? '0 : base;
			t.price = $urandom_range(1) ? base + delta : base - delta;
			t.qty = ($urandom_range(99) < 85) ? $urandom_range(32'h7fffffff, 1) : $urandom;
		end
		return t;
	endfunction

	function automatic logic [FRAC_W-1:0] rand_frac();
		case ($urandom_range(9))
			0: return '0;
			1: return FRAC_ONE;
			2: return FRAC_W'($urandom_range(32'(FRAC_ONE), 0));
			default: return FRAC_W'($urandom_range(32'h3000, 32'h0400));
		endcase
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch on sell %0d: %s got %0h expected %0h", sells_seen, what, got, want);
		errors++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAC_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CHECKS_EN:  chk_en = val[0];
			CFG_STOP_FRAC:  stop_frac = val;
			CFG_TRAIL_EN:   trail_en = val[0];
			CFG_TRAIL_FRAC: trail_frac = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic en, logic [FRAC_W-1:0] sf, logic ten, logic [FRAC_W-1:0] tf);
		write_reg(CFG_CHECKS_EN, FRAC_W'(en));
		write_reg(CFG_STOP_FRAC, sf);
		write_reg(CFG_TRAIL_EN, FRAC_W'(ten));
		write_reg(CFG_TRAIL_FRAC, tf);
	endtask

	// wait until every queued tick has its sell decision back
	task automatic drain();
		while (pending_ticks.size() != 0 || expected_sells.size() != 0 || in_valid)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// driver: load the next tick after each transfer, with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_sells.insert(expected_sells.size(), judge_tick(drv_tick));
			if (!in_valid || !in_stall) begin
				if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					drv_tick = pending_ticks.pop_front();
					in_valid <= 1'b1;
					action <= drv_tick.action;
					symbol_index <= drv_tick.symbol;
					tick_price <= drv_tick.price;
					held_qty <= drv_tick.qty;
					average_cost <= drv_tick.cost;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each sell transfer, stall at random, one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_sells.size() == 0) begin
					report("unexpected sell transfer, symbol", 64'(sell_symbol), '0);
				end else begin
					sell_t want;
					want = expected_sells.pop_front();
					if (sell_trigger !== want.trig)
						report("sell_trigger", 64'(sell_trigger), 64'(want.trig));
					if (trigger_reason !== want.reason)
						report("trigger_reason", 64'(trigger_reason), 64'(want.reason));
					if (sell_symbol !== want.symbol)
						report("sell_symbol", 64'(sell_symbol), 64'(want.symbol));
					if (sell_qty !== want.qty)
						report("sell_qty", 64'(sell_qty), 64'(want.qty));
				end
				sells_seen++;
				if (sells_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("timeout after %0d cycles without a transfer", stuck_cycles);
				$display("trailing_stop_loss_check verification failed");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_SYMBOLS; i++)
			peak_tab[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: checks off, nothing triggers
		add_tick(mk_tick(ACTION_CHECK, 6'd0, 32'd0, 32'd100, 32'd1000));
		add_tick(mk_tick(ACTION_CHECK, 6'd3, 32'd10, 32'd7, 32'd900));
		add_tick(mk_tick(ACTION_CLEAR, 6'd3, 32'd0, 32'd0, 32'd0));
		drain();

		// fixed stop at full loss, trailing at one eighth
		set_config(1'b1, FRAC_ONE, 1'b1, FRAC_W'(32'h2000));
		add_tick(mk_tick(ACTION_CHECK, 6'd0, 32'd0, 32'd100, 32'd1000));
		add_tick(mk_tick(ACTION_CHECK, 6'd1, 32'd1000, 32'd5, 32'd1000));
		add_tick(mk_tick(ACTION_CHECK, 6'd1, 32'd1200, 32'd5, 32'd1000));
		// drop exactly at the trailing threshold, then just under it
		add_tick(mk_tick(ACTION_CHECK, 6'd1, 32'd1050, 32'd5, 32'd1000));
		add_tick(mk_tick(ACTION_CHECK, 6'd1, 32'd1051, 32'd5, 32'd1000));
		add_tick(mk_tick(ACTION_CLEAR, 6'd1, 32'hffffffff, 32'hffffffff,
			32'hffffffff));
		// cleared symbol reloads its peak from the cost
		add_tick(mk_tick(ACTION_CHECK, 6'd1, 32'd1050, 32'd5, 32'd1000));
		add_tick(mk_tick(ACTION_CHECK, 6'd63, 32'hffffffff, 32'h7fffffff,
			32'hffffffff));
		add_tick(mk_tick(ACTION_CHECK, 6'd63, 32'he0000000, 32'h7fffffff,
			32'hffffffff));
		add_tick(mk_tick(ACTION_CHECK, 6'd63, 32'hdfffffff, 32'h7fffffff,
			32'hffffffff));
		// zero or negative quantity and zero cost never check, then a full loss at the largest quantity
		add_tick(mk_tick(ACTION_CHECK, 6'd2, 32'd0, 32'd0, 32'd1000));
		add_tick(mk_tick(ACTION_CHECK, 6'd2, 32'd0, 32'hffffffff, 32'd1000));
		add_tick(mk_tick(ACTION_CHECK, 6'd2, 32'd0, 32'h80000000, 32'd1000));
		add_tick(mk_tick(ACTION_CHECK, 6'd2, 32'd0, 32'd9, 32'd0));
		add_tick(mk_tick(ACTION_CHECK, 6'd2, 32'd0, 32'h7fffffff, 32'd1));
		drain();

		// zero fixed threshold: any loss of zero or more triggers
		set_config(1'b1, '0, 1'b0, FRAC_ONE);
		add_tick(mk_tick(ACTION_CHECK, 6'd4, 32'd500, 32'd3, 32'd500));
		add_tick(mk_tick(ACTION_CHECK, 6'd4, 32'd501, 32'd3, 32'd500));
		add_tick(mk_tick(ACTION_CHECK, 6'd4, 32'd0, 32'd3, 32'hffffffff));
		drain();

		// zero trailing threshold under a quarter fixed stop
		set_config(1'b1, FRAC_W'(32'h4000), 1'b1, '0);
		add_tick(mk_tick(ACTION_CHECK, 6'd5, 32'd1000, 32'd8, 32'd1000));
		add_tick(mk_tick(ACTION_CHECK, 6'd5, 32'd749, 32'd8, 32'd1000));
		drain();

		// checks off with trailing on
		set_config(1'b0, '0, 1'b1, '0);
		add_tick(mk_tick(ACTION_CHECK, 6'd6, 32'd0, 32'd8, 32'd1000));
		add_tick(mk_tick(ACTION_CLEAR, 6'd6, 32'd0, 32'd8, 32'd1000));
		drain();

		// random settings and ticks, one phase without any idling
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_config(($urandom_range(9) != 0), rand_frac(), $urandom_range(1), rand_frac());
			steady = (p == 1);
			for (int n = 0; n < PHASE_TICKS; n++)
				add_tick(rand_tick());
			drain();
		end
		steady = 1'b0;

		if (errors == 0)
			$display("trailing_stop_loss_check verification clean");
		else
			$display("trailing_stop_loss_check verification failed");
		$finish;
	end

endmodule
